// ===== hdl/mlrr_pkg.sv =====
`timescale 1ns / 1ps

package mlrr_pkg;

  localparam int DISPLAY_HEIGHT_DEF = 152;
  localparam int DISPLAY_WIDTH_DEF  = 128;

  localparam int CMD_W  = 2;
  localparam int X_W    = 7;
  localparam int Y_W    = 8;
  localparam int BA_W   = 12;
  localparam int DATA_W = 8;
  localparam int SEG_W  = 2;

  localparam logic [DATA_W-1:0] LEFT_PIXEL_MASK = 8'h80;

  typedef enum logic [CMD_W-1:0] {
    CMD_LINE    = 2'd0,
    CMD_OUTLINE = 2'd1,
    CMD_FILL    = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [SEG_W-1:0] {
    SEG_TOP    = 2'd0,
    SEG_RIGHT  = 2'd1,
    SEG_BOTTOM = 2'd2,
    SEG_LEFT   = 2'd3
  } seg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SEG,
    S_WALK,
    S_DRAIN,
    S_READ,
    S_RWAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic seg_load;
    seg_t seg;
    logic issue;
    logic rd_issue;
    logic rd_capture;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic diag;
    logic walk_last;
    logic clear_last;
  } dp_status_t;

endpackage

// ===== hdl/mlrr_ram.sv =====
`timescale 1ns / 1ps

module mlrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2432
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the address being written returns the old byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mlrr_datapath.sv =====
`timescale 1ns / 1ps

module mlrr_datapath #(
  parameter int DISPLAY_HEIGHT = mlrr_pkg::DISPLAY_HEIGHT_DEF,
  parameter int DISPLAY_WIDTH  = mlrr_pkg::DISPLAY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mlrr_pkg::ctrl_cmd_t             cmd,
  output mlrr_pkg::dp_status_t            status,
  input  logic [mlrr_pkg::CMD_W-1:0]      in_command,
  input  logic [mlrr_pkg::X_W-1:0]        in_x_first,
  input  logic [mlrr_pkg::Y_W-1:0]        in_y_first,
  input  logic [mlrr_pkg::X_W-1:0]        in_x_second,
  input  logic [mlrr_pkg::Y_W-1:0]        in_y_second,
  input  logic                            in_ink,
  input  logic [mlrr_pkg::BA_W-1:0]       in_byte_address,
  output logic [mlrr_pkg::DATA_W-1:0]     out_read_data,
  output logic                            out_not_drawn
);

  import mlrr_pkg::*;

  localparam int BYTE_COLUMNS = (DISPLAY_WIDTH + 7) / 8;
  localparam int STORE_BYTES  = BYTE_COLUMNS * DISPLAY_HEIGHT;
  localparam int AW           = $clog2(STORE_BYTES);

  // latched command
  cmd_t              cmd_r;
  logic              diag_r;
  logic              ink_r;
  logic [X_W-1:0]    xl_r, xh_r;
  logic [Y_W-1:0]    yl_r, yh_r;
  logic [BA_W-1:0]   ba_r;
  logic              ba_ok_r;

  // box walker
  logic [X_W-1:0]    bx0_r, bx1_r, x_r;
  logic [Y_W-1:0]    by1_r, y_r;
  logic [AW-1:0]     col_r, row_base_r;

  // read-modify-write second stage and write forwarding
  logic              p_valid_r;
  logic [AW-1:0]     p_addr_r;
  logic [DATA_W-1:0] p_mask_r;
  logic              fwd_valid_r;
  logic [AW-1:0]     fwd_addr_r;
  logic [DATA_W-1:0] fwd_data_r;

  logic [AW-1:0]     clr_r;
  logic [DATA_W-1:0] rb_data_r;
  logic [DATA_W-1:0] out_read_data_r;
  logic              out_not_drawn_r;

  logic [X_W-1:0]    sx0, sx1;
  logic [Y_W-1:0]    sy0, sy1;
  logic [AW-1:0]     base_ld;
  logic              px_ok;
  logic [AW-1:0]     walk_addr;
  logic [AW-1:0]     ram_raddr, ram_waddr;
  logic [DATA_W-1:0] ram_rdata, ram_wdata;
  logic              ram_we;
  logic [DATA_W-1:0] old_byte, new_byte;
  logic              full_box;

  // segment bounds, top edge covers the whole box for line and fill
  always_comb begin
    full_box = (cmd_r != CMD_OUTLINE);
    unique case (cmd.seg)
      SEG_TOP: begin
        sx0 = xl_r; sy0 = yl_r; sx1 = xh_r; sy1 = full_box ? yh_r : yl_r;
      end
      SEG_RIGHT: begin
        sx0 = xh_r; sy0 = yl_r; sx1 = xh_r; sy1 = yh_r;
      end
      SEG_BOTTOM: begin
        sx0 = xl_r; sy0 = yh_r; sx1 = xh_r; sy1 = yh_r;
      end
      SEG_LEFT: begin
        sx0 = xl_r; sy0 = yl_r; sx1 = xl_r; sy1 = yh_r;
      end
      default: begin
        sx0 = xl_r; sy0 = yl_r; sx1 = xh_r; sy1 = yh_r;
      end
    endcase
  end

  // byte column base of the starting x; columns past the display wrap but are clipped
  assign base_ld = AW'(32'(sx0[X_W-1:3]) * DISPLAY_HEIGHT);

  assign px_ok     = (32'(x_r) < DISPLAY_WIDTH) && (32'(y_r) < DISPLAY_HEIGHT);
  assign walk_addr = col_r + AW'(y_r);

  assign ram_raddr = cmd.rd_issue ? AW'(ba_r) : walk_addr;
  assign old_byte  = (fwd_valid_r && fwd_addr_r == p_addr_r) ? fwd_data_r : ram_rdata;
  assign new_byte  = ink_r ? (old_byte | p_mask_r) : (old_byte & ~p_mask_r);
  assign ram_we    = cmd.clear || p_valid_r;
  assign ram_waddr = cmd.clear ? clr_r : p_addr_r;
  assign ram_wdata = cmd.clear ? '0 : new_byte;

  mlrr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      p_valid_r   <= cmd.issue && px_ok;
      fwd_valid_r <= p_valid_r;
      if (cmd.clear) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p_addr_r   <= walk_addr;
    p_mask_r   <= LEFT_PIXEL_MASK >> x_r[2:0];
    fwd_addr_r <= p_addr_r;
    fwd_data_r <= new_byte;

    if (cmd.load) begin
      cmd_r     <= cmd_t'(in_command);
      diag_r    <= (in_x_first != in_x_second) && (in_y_first != in_y_second);
      ink_r     <= in_ink;
      xl_r      <= (in_x_first < in_x_second) ? in_x_first : in_x_second;
      xh_r      <= (in_x_first < in_x_second) ? in_x_second : in_x_first;
      yl_r      <= (in_y_first < in_y_second) ? in_y_first : in_y_second;
      yh_r      <= (in_y_first < in_y_second) ? in_y_second : in_y_first;
      ba_r      <= in_byte_address;
      ba_ok_r   <= (32'(in_byte_address) < STORE_BYTES);
      rb_data_r <= '0;
    end else if (cmd.rd_capture) begin
      rb_data_r <= ba_ok_r ? ram_rdata : '0;
    end

    if (cmd.seg_load) begin
      bx0_r      <= sx0;
      bx1_r      <= sx1;
      by1_r      <= sy1;
      x_r        <= sx0;
      y_r        <= sy0;
      col_r      <= base_ld;
      row_base_r <= base_ld;
    end else if (cmd.issue) begin
      if (x_r == bx1_r) begin
        x_r   <= bx0_r;
        y_r   <= y_r + Y_W'(1);
        col_r <= row_base_r;
      end else begin
        x_r <= x_r + X_W'(1);
        if (x_r[2:0] == 3'd7) begin
          col_r <= col_r + AW'(DISPLAY_HEIGHT);
        end
      end
    end

    if (cmd.res_load) begin
      out_read_data_r <= rb_data_r;
      out_not_drawn_r <= (cmd_r == CMD_LINE) && diag_r;
    end
  end

  assign status.cmd        = cmd_r;
  assign status.diag       = diag_r;
  assign status.walk_last  = (x_r == bx1_r) && (y_r == by1_r);
  assign status.clear_last = (clr_r == AW'(STORE_BYTES - 1));

  assign out_read_data = out_read_data_r;
  assign out_not_drawn = out_not_drawn_r;

  a_clear_no_draw: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clear && p_valid_r))
    else $error("pixel write during store clear");

  a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (32'(p_addr_r) < STORE_BYTES))
    else $error("pixel write beyond store");

endmodule

// ===== hdl/mlrr_ctrl.sv =====
`timescale 1ns / 1ps

module mlrr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  mlrr_pkg::dp_status_t  status,
  output mlrr_pkg::ctrl_cmd_t   cmd
);

  import mlrr_pkg::*;

  state_t state_r, state_nxt;
  seg_t   seg_r, seg_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      seg_r       <= SEG_TOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd           = '0;
    cmd.seg       = seg_r;

    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        seg_nxt = SEG_TOP;
        unique case (status.cmd)
          CMD_LINE:    state_nxt = status.diag ? S_DONE : S_SEG;
          CMD_OUTLINE: state_nxt = S_SEG;
          CMD_FILL:    state_nxt = S_SEG;
          CMD_READ:    state_nxt = S_READ;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_SEG: begin
        cmd.seg_load = 1'b1;
        state_nxt    = S_WALK;
      end
      S_WALK: begin
        cmd.issue = 1'b1;
        if (status.walk_last) begin
          if (status.cmd == CMD_OUTLINE && seg_r != SEG_LEFT) begin
            seg_nxt   = seg_t'(seg_r + SEG_W'(1));
            state_nxt = S_SEG;
          end else begin
            state_nxt = S_DRAIN;
          end
        end
      end
      // last pixel write lands here
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted word not decoded");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || !out_stall))
    else $error("result overwrites a waiting word");

  a_seg_outline_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEG && seg_r != SEG_TOP) |-> (status.cmd == CMD_OUTLINE))
    else $error("extra segment for a non-outline command");

  a_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

// ===== hdl/mono_line_rect_raster_unit.sv =====
`timescale 1ns / 1ps

// Drawing engine for a one-bit-per-pixel display store of
// ((DISPLAY_WIDTH+7)/8)*DISPLAY_HEIGHT bytes, pixel (x,y) at byte (x/8)*DISPLAY_HEIGHT+y,
// bit 7-(x mod 8). After reset the store is swept to zero one byte a cycle, and no
// word is taken until that ends. Each word carries one command and gives one result
// word. Drawing walks the clipped-or-not bounding box of each segment one pixel per
// cycle through a read-modify-write on the single store write port (forwarding keeps
// back-to-back pixels in one byte correct). A new word is taken while the previous
// result still waits at the output.
module mono_line_rect_raster_unit #(
  parameter int DISPLAY_HEIGHT = mlrr_pkg::DISPLAY_HEIGHT_DEF,
  parameter int DISPLAY_WIDTH  = mlrr_pkg::DISPLAY_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mlrr_pkg::CMD_W-1:0]   in_command,
  input  logic [mlrr_pkg::X_W-1:0]     in_x_first,
  input  logic [mlrr_pkg::Y_W-1:0]     in_y_first,
  input  logic [mlrr_pkg::X_W-1:0]     in_x_second,
  input  logic [mlrr_pkg::Y_W-1:0]     in_y_second,
  input  logic                         in_ink,
  input  logic [mlrr_pkg::BA_W-1:0]    in_byte_address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mlrr_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_not_drawn
);

  import mlrr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mlrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mlrr_datapath #(
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .DISPLAY_WIDTH  (DISPLAY_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_command      (in_command),
    .in_x_first      (in_x_first),
    .in_y_first      (in_y_first),
    .in_x_second     (in_x_second),
    .in_y_second     (in_y_second),
    .in_ink          (in_ink),
    .in_byte_address (in_byte_address),
    .out_read_data   (out_read_data),
    .out_not_drawn   (out_not_drawn)
  );

endmodule
